[src/haar_question_mark_matrix_element_assert.svh]
// Assertion macros shared by the checker of the question-mark matrix element block.
`ifndef HAAR_QUESTION_MARK_MATRIX_ELEMENT_ASSERT_SVH
`define HAAR_QUESTION_MARK_MATRIX_ELEMENT_ASSERT_SVH
// The consequent must hold in the same cycle as the antecedent.
`define HQME_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hqme assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define HQME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hqme assertion failed");
`endif

[src/hqme_pkg.sv]
// Package of types and constants for the question-mark matrix element block.
`timescale 1ns / 1ps
package hqme_pkg;
	localparam int MAX_LEVEL_DEF = 16;
	localparam int FRAC_BITS_DEF = 32;
	localparam int OUT_W = 49;
	localparam int MAG_W = 42;
	localparam logic [31:0] SQRT2_FRAC = 32'h6A09E668;
	localparam logic [1:0] PT_LO = 2'd0;
	localparam logic [1:0] PT_HI = 2'd1;
	localparam logic [1:0] PT_MID = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_PSEL, ST_WALK, ST_DIV, ST_PNEXT,
		ST_SPAN, ST_SUM, ST_MULA, ST_MULB, ST_FIN
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP, DP_LOAD, DP_PSEL, DP_WALK, DP_DIV, DP_SPAN,
		DP_SUM, DP_MULA, DP_MULB, DP_FIN
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] pt;
	} cmd_t;

	typedef struct packed {
		logic idx_err;
		logic trivial;
		logic walk_hit;
		logic div_last;
	} status_t;
endpackage

[src/hqme_ctrl.sv]
// Controller state machine that sequences the point walks, divisions and final scaling.
`timescale 1ns / 1ps
module hqme_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  hqme_pkg::status_t status,
	output hqme_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              done
);
	hqme_pkg::state_t state_q, state_d;
	logic [1:0] pt_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hqme_pkg::ST_IDLE;
			pt_q <= hqme_pkg::PT_LO;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == hqme_pkg::ST_FIN);
			if (state_q == hqme_pkg::ST_PNEXT) begin
				pt_q <= (pt_q == hqme_pkg::PT_MID) ? hqme_pkg::PT_LO : pt_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			hqme_pkg::ST_IDLE:  if (start) state_d = hqme_pkg::ST_CHECK;
			hqme_pkg::ST_CHECK: state_d = status.idx_err ? hqme_pkg::ST_FIN : hqme_pkg::ST_PSEL;
			hqme_pkg::ST_PSEL:  state_d = status.trivial ? hqme_pkg::ST_PNEXT : hqme_pkg::ST_WALK;
			hqme_pkg::ST_WALK:  if (status.walk_hit) state_d = hqme_pkg::ST_DIV;
			hqme_pkg::ST_DIV:   if (status.div_last) state_d = hqme_pkg::ST_PNEXT;
			hqme_pkg::ST_PNEXT: begin
				state_d = (pt_q == hqme_pkg::PT_MID) ? hqme_pkg::ST_SPAN : hqme_pkg::ST_PSEL;
			end
			hqme_pkg::ST_SPAN:  state_d = hqme_pkg::ST_SUM;
			hqme_pkg::ST_SUM:   state_d = hqme_pkg::ST_MULA;
			hqme_pkg::ST_MULA:  state_d = hqme_pkg::ST_MULB;
			hqme_pkg::ST_MULB:  state_d = hqme_pkg::ST_FIN;
			hqme_pkg::ST_FIN:   state_d = hqme_pkg::ST_IDLE;
			default:            state_d = hqme_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.pt = pt_q;
		case (state_q)
			hqme_pkg::ST_IDLE:  cmd.op = start ? hqme_pkg::DP_LOAD : hqme_pkg::DP_NOP;
			hqme_pkg::ST_PSEL:  cmd.op = hqme_pkg::DP_PSEL;
			hqme_pkg::ST_WALK:  cmd.op = hqme_pkg::DP_WALK;
			hqme_pkg::ST_DIV:   cmd.op = hqme_pkg::DP_DIV;
			hqme_pkg::ST_SPAN:  cmd.op = hqme_pkg::DP_SPAN;
			hqme_pkg::ST_SUM:   cmd.op = hqme_pkg::DP_SUM;
			hqme_pkg::ST_MULA:  cmd.op = hqme_pkg::DP_MULA;
			hqme_pkg::ST_MULB:  cmd.op = hqme_pkg::DP_MULB;
			hqme_pkg::ST_FIN:   cmd.op = hqme_pkg::DP_FIN;
			default:            cmd.op = hqme_pkg::DP_NOP;
		endcase
	end

	assign busy = (state_q != hqme_pkg::ST_IDLE);
	assign done = done_q;
endmodule

[src/hqme_datapath.sv]
// Datapath: operand registers, Stern-Brocot walker, serial divider, overlap sum and scaling.
`timescale 1ns / 1ps
module hqme_datapath #(
	parameter int MAX_LEVEL = hqme_pkg::MAX_LEVEL_DEF,
	parameter int FRAC_BITS = hqme_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hqme_pkg::cmd_t                    cmd,
	output hqme_pkg::status_t                 status,
	input  logic [3:0]                        row_level,
	input  logic [15:0]                       row_offset,
	input  logic [3:0]                        col_level,
	input  logic [15:0]                       col_offset,
	output logic signed [hqme_pkg::OUT_W-1:0] element_value,
	output logic                              index_error
);
	localparam int PT_W = FRAC_BITS + 1;
	localparam int D_W = MAX_LEVEL + 1;
	localparam int SB_W = MAX_LEVEL + 2;
	localparam int N_W = SB_W + FRAC_BITS;
	localparam int CNT_W = $clog2(FRAC_BITS + 1);
	localparam int LV_W = $clog2(MAX_LEVEL + 1);
	localparam int S_W = PT_W + 2;
	localparam logic [63:0] OUT_MAX = 64'h0000_FFFF_FFFF_FFFF;
	localparam logic [63:0] OUT_MIN_MAG = 64'h0001_0000_0000_0000;

	logic [3:0] j_q, l_q;
	logic [15:0] k_q, m_q;
	logic err_q;
	logic [D_W-1:0] a_q, lo_q, hi_q;
	logic [SB_W-1:0] lp_q, lq_q, hp_q, hq_q, qd_q;
	logic [SB_W:0] rem_q;
	logic [FRAC_BITS:0] nlow_q;
	logic [PT_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PT_W-1:0] f_q [3];
	logic [PT_W-1:0] s0_q, s1_q, s2_q, s3_q;
	logic zero_q, neg_q;
	logic [hqme_pkg::MAG_W-1:0] mag_q;
	logic [63:0] prodl_q;
	logic [41:0] prodh_q;
	logic signed [hqme_pkg::OUT_W-1:0] val_q;
	logic ierr_q;

	// Operand selection for the point being walked.
	logic [31:0] a_wide;
	logic [LV_W-1:0] n_sel;
	logic [D_W-1:0] a_sel, full_sel, mid;
	logic [D_W:0] lohi;
	logic [SB_W-1:0] mp, mq;
	logic [N_W-1:0] numer;
	logic [SB_W:0] rsh;
	logic rge;
	logic in_err;

	always_comb begin
		case (cmd.pt)
			hqme_pkg::PT_LO:  a_wide = {16'd0, k_q};
			hqme_pkg::PT_HI:  a_wide = {16'd0, k_q} + 32'd1;
			hqme_pkg::PT_MID: a_wide = {15'd0, k_q, 1'b1};
			default:          a_wide = 32'd0;
		endcase
		n_sel = (cmd.pt == hqme_pkg::PT_MID) ? LV_W'(j_q) + LV_W'(1) : LV_W'(j_q);
		a_sel = a_wide[D_W-1:0];
		full_sel = D_W'(1) << n_sel;
		lohi = {1'b0, lo_q} + {1'b0, hi_q};
		mid = lohi[D_W:1];
		mp = lp_q + hp_q;
		mq = lq_q + hq_q;
		numer = {mp, {FRAC_BITS{1'b0}}} + N_W'(mq >> 1);
		rsh = {rem_q[SB_W-1:0], nlow_q[FRAC_BITS]};
		rge = (rsh >= {1'b0, qd_q});
		in_err = ({1'b0, row_level} >= 5'(MAX_LEVEL)) || ({1'b0, col_level} >= 5'(MAX_LEVEL))
			|| ((row_offset >> row_level) != 16'd0) || ((col_offset >> col_level) != 16'd0);
	end

	assign status.idx_err = err_q;
	assign status.trivial = (a_sel == '0) || (a_sel >= full_sel);
	assign status.walk_hit = (a_q == mid);
	assign status.div_last = (cnt_q == CNT_W'(FRAC_BITS));

	// Haar-side points.
	logic [PT_W-1:0] h_lo, h_hi, h_mid;
	assign h_lo = PT_W'(m_q) << (FRAC_BITS - int'(l_q));
	assign h_hi = (PT_W'(m_q) + PT_W'(1)) << (FRAC_BITS - int'(l_q));
	assign h_mid = PT_W'({m_q, 1'b1}) << (FRAC_BITS - int'(l_q) - 1);

	function automatic logic [PT_W-1:0] span(input logic [PT_W-1:0] alo, input logic [PT_W-1:0] ahi,
		input logic [PT_W-1:0] blo, input logic [PT_W-1:0] bhi);
		logic [PT_W-1:0] bot, top;
		bot = (alo < blo) ? blo : alo;
		top = (bhi < ahi) ? bhi : ahi;
		return (top <= bot) ? '0 : top - bot;
	endfunction

	logic [PT_W-1:0] fl, fh, fm;
	logic zero_c;
	logic signed [S_W-1:0] sum_c, abs_c;
	logic [4:0] p_sum;
	logic [63:0] t_c, sel_c, sh_c;

	always_comb begin
		fl = f_q[0];
		fh = f_q[1];
		fm = f_q[2];
		zero_c = (h_hi <= fl) || (h_lo >= fh) || ((h_lo <= fl) && (fh <= h_mid))
			|| ((h_mid <= fl) && (fh <= h_hi)) || ((fl <= h_lo) && (h_hi <= fm))
			|| ((fm <= h_lo) && (h_hi <= fh));
		sum_c = S_W'(s0_q) - S_W'(s1_q) - S_W'(s2_q) + S_W'(s3_q);
		abs_c = sum_c[S_W-1] ? -sum_c : sum_c;
		p_sum = {1'b0, j_q} + {1'b0, l_q};
		t_c = 64'(mag_q) + 64'(prodh_q) + ((prodl_q + 64'h8000_0000) >> 32);
		sel_c = p_sum[0] ? t_c : 64'(mag_q);
		sh_c = sel_c << p_sum[4:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= 1'b0;
		end else if (cmd.op == hqme_pkg::DP_LOAD) begin
			err_q <= in_err;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			hqme_pkg::DP_LOAD: begin
				j_q <= row_level;
				k_q <= row_offset;
				l_q <= col_level;
				m_q <= col_offset;
			end
			hqme_pkg::DP_PSEL: begin
				a_q <= a_sel;
				lo_q <= '0;
				hi_q <= full_sel;
				lp_q <= '0;
				lq_q <= SB_W'(1);
				hp_q <= SB_W'(1);
				hq_q <= SB_W'(1);
				if (a_sel == '0) begin
					f_q[cmd.pt] <= '0;
				end else begin
					f_q[cmd.pt] <= PT_W'(1) << FRAC_BITS;
				end
			end
			hqme_pkg::DP_WALK: begin
				if (a_q == mid) begin
					rem_q <= {2'b00, numer[N_W-1:FRAC_BITS+1]};
					nlow_q <= numer[FRAC_BITS:0];
					qd_q <= mq;
					cnt_q <= '0;
				end else if (a_q < mid) begin
					hi_q <= mid;
					hp_q <= mp;
					hq_q <= mq;
				end else begin
					lo_q <= mid;
					lp_q <= mp;
					lq_q <= mq;
				end
			end
			hqme_pkg::DP_DIV: begin
				rem_q <= rge ? rsh - {1'b0, qd_q} : rsh;
				nlow_q <= {nlow_q[FRAC_BITS-1:0], 1'b0};
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(FRAC_BITS)) begin
					f_q[cmd.pt] <= {quo_q[PT_W-2:0], rge};
				end
				quo_q <= {quo_q[PT_W-2:0], rge};
			end
			hqme_pkg::DP_SPAN: begin
				zero_q <= zero_c;
				s0_q <= span(h_lo, h_mid, fl, fm);
				s1_q <= span(h_lo, h_mid, fm, fh);
				s2_q <= span(h_mid, h_hi, fl, fm);
				s3_q <= span(h_mid, h_hi, fm, fh);
			end
			hqme_pkg::DP_SUM: begin
				neg_q <= sum_c[S_W-1] && !zero_q;
				mag_q <= zero_q ? '0 : hqme_pkg::MAG_W'(abs_c);
			end
			hqme_pkg::DP_MULA: prodl_q <= 64'(mag_q[31:0]) * 64'(hqme_pkg::SQRT2_FRAC);
			hqme_pkg::DP_MULB: prodh_q <= 42'(mag_q[41:32]) * 42'(hqme_pkg::SQRT2_FRAC);
			hqme_pkg::DP_FIN: begin
				ierr_q <= err_q;
				if (err_q) begin
					val_q <= '0;
				end else if (neg_q) begin
					val_q <= (sh_c > OUT_MIN_MAG) ? hqme_pkg::OUT_W'(-64'(OUT_MIN_MAG))
						: hqme_pkg::OUT_W'(-sh_c);
				end else begin
					val_q <= (sh_c > OUT_MAX) ? hqme_pkg::OUT_W'(OUT_MAX) : hqme_pkg::OUT_W'(sh_c);
				end
			end
			default: ;
		endcase
	end

	assign element_value = val_q;
	assign index_error = ierr_q;
endmodule

[src/haar_question_mark_matrix_element.sv]
// Top level of the question-mark transfer operator matrix element block.
`timescale 1ns / 1ps
// One request at a time: a request is taken when start is high while busy is low, and its
// result appears for exactly one cycle with done high; the receiver cannot stall, so it must
// capture element_value and index_error in that cycle. An out-of-range request is flagged in
// the check state and goes straight to the final state, which registers its zero result and
// raises done. A valid request takes the three Farey points in turn: a point at 0 or 1 is
// set directly, any other is walked down the Stern-Brocot tree, no deeper than its level (j
// for the two ends, j + 1 for the midpoint), and then divided out by the one-bit-a-cycle
// restoring divider. The walker and the divider are shared by the three points. The overlap
// sum is then scaled; the sqrt2 product is formed in two multiplies on successive cycles,
// the low 32 bits and the high 10 bits of the magnitude each times the 32-bit constant.
module haar_question_mark_matrix_element #(
	parameter int MAX_LEVEL = hqme_pkg::MAX_LEVEL_DEF,
	parameter int FRAC_BITS = hqme_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	output logic                              done,
	input  logic [3:0]                        row_level,
	input  logic [15:0]                       row_offset,
	input  logic [3:0]                        col_level,
	input  logic [15:0]                       col_offset,
	output logic signed [hqme_pkg::OUT_W-1:0] element_value,
	output logic                              index_error
);
	// Commands flow from the controller to the datapath, status flows back.
	hqme_pkg::cmd_t cmd;
	hqme_pkg::status_t status;

	hqme_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.status(status),
		.cmd(cmd),
		.busy(busy),
		.done(done)
	);

	hqme_datapath #(
		.MAX_LEVEL(MAX_LEVEL),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.row_level(row_level),
		.row_offset(row_offset),
		.col_level(col_level),
		.col_offset(col_offset),
		.element_value(element_value),
		.index_error(index_error)
	);
endmodule

[src/hqme_checker.sv]
// Port-level checker for the question-mark matrix element block, with its bind.
`timescale 1ns / 1ps
`include "haar_question_mark_matrix_element_assert.svh"
module hqme_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic signed [hqme_pkg::OUT_W-1:0] element_value,
	input logic                              index_error
);
	`HQME_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`HQME_ASSERT_NEXT(a_accept_no_done, clk, arst_n, start && !busy, !done)
	`HQME_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)
	`HQME_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`HQME_ASSERT_NOW(a_err_zero, clk, arst_n, done && index_error, element_value == '0)
endmodule

bind haar_question_mark_matrix_element hqme_checker u_chk (.*);

[tb/tb_haar_question_mark_matrix_element.sv]
// Self-checking testbench for the question-mark transfer operator matrix element block.
`timescale 1ns / 1ps
module tb_haar_question_mark_matrix_element;
	// One request: a pair of wavelet indices, plus a flag that makes the driver hold
	// the request back until every outstanding result has come home.
	typedef struct {
		logic [3:0]  row_level;
		logic [15:0] row_offset;
		logic [3:0]  col_level;
		logic [15:0] col_offset;
		logic        drain_first;
	} wavelet_pair_t;

	typedef struct {
		logic signed [hqme_pkg::OUT_W-1:0] value;
		logic                              err;
	} element_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_PAIRS = 900;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [3:0] row_level = '0;
	logic [15:0] row_offset = '0;
	logic [3:0] col_level = '0;
	logic [15:0] col_offset = '0;
	logic busy, done, index_error;
	logic signed [hqme_pkg::OUT_W-1:0] element_value;

	wavelet_pair_t pair_queue[$];
	element_t expected_elements[$];
	int issued = 0;
	int mismatches = 0;
	int results_seen = 0;
	int nonzero_seen = 0;
	int error_seen = 0;
	int idle_cycles = 0;

	haar_question_mark_matrix_element dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.row_level(row_level), .row_offset(row_offset),
		.col_level(col_level), .col_offset(col_offset),
		.element_value(element_value), .index_error(index_error)
	);

	always #5 clk = ~clk;

	// Stern-Brocot image of the dyadic point a/2^n, in unsigned fixed point with 32
	// fractional bits. The walk descends the tree until it meets the point itself.
	function automatic logic [63:0] stern_brocot_point(int n, logic [63:0] a);
		logic [63:0] full, lo_d, hi_d, mid, lp, lq, hp, hq, mp, mq;
		full = 64'd1 << n;
		lo_d = 0; hi_d = full;
		lp = 0; lq = 1; hp = 1; hq = 1; mp = 1; mq = 2;
		if (a == 0)
			return 64'd0;
		if (a >= full)
			return 64'd1 << 32;
		for (int i = 0; i <= n; i++) begin
			mid = (lo_d + hi_d) >> 1;
			mp = lp + hp;
			mq = lq + hq;
			if (a == mid)
				break;
			if (a < mid) begin
				hi_d = mid; hp = mp; hq = mq;
			end else begin
				lo_d = mid; lp = mp; lq = mq;
			end
		end
		return ((mp << 32) + (mq >> 1)) / mq;
	endfunction

	function automatic longint overlap(logic [63:0] alo, logic [63:0] ahi,
			logic [63:0] blo, logic [63:0] bhi);
		logic [63:0] bot, top;
		bot = (alo < blo) ? blo : alo;
		top = (bhi < ahi) ? bhi : ahi;
		if (top <= bot)
			return 0;
		return longint'(top - bot);
	endfunction

	// Computes the matrix element for one index pair, with the same rounding and
	// saturation as the hardware.
	function automatic element_t matrix_element(wavelet_pair_t w);
		element_t r;
		logic [63:0] k, m, h_lo, h_mid, h_hi, f_lo, f_mid, f_hi, mag, sq;
		longint sum;
		int j, l, p;
		logic neg;
		j = w.row_level; l = w.col_level;
		k = w.row_offset; m = w.col_offset;
		r.value = '0;
		r.err = 1'b0;
		if (j >= hqme_pkg::MAX_LEVEL_DEF || l >= hqme_pkg::MAX_LEVEL_DEF ||
				k >= (64'd1 << j) || m >= (64'd1 << l)) begin
			r.err = 1'b1;
			return r;
		end
		h_lo = m << (32 - l);
		h_hi = (m + 1) << (32 - l);
		h_mid = (2 * m + 1) << (31 - l);
		f_lo = stern_brocot_point(j, k);
		f_hi = stern_brocot_point(j, k + 1);
		f_mid = stern_brocot_point(j + 1, 2 * k + 1);
		// Disjoint supports, or one support inside a single half of the other.
		if (h_hi <= f_lo || h_lo >= f_hi) return r;
		if (h_lo <= f_lo && f_hi <= h_mid) return r;
		if (h_mid <= f_lo && f_hi <= h_hi) return r;
		if (f_lo <= h_lo && h_hi <= f_mid) return r;
		if (f_mid <= h_lo && h_hi <= f_hi) return r;
		sum = overlap(h_lo, h_mid, f_lo, f_mid) - overlap(h_lo, h_mid, f_mid, f_hi)
			- overlap(h_mid, h_hi, f_lo, f_mid) + overlap(h_mid, h_hi, f_mid, f_hi);
		neg = sum < 0;
		mag = neg ? 64'(-sum) : 64'(sum);
		p = j + l;
		if (p % 2 == 1) begin
			sq = 64'(hqme_pkg::SQRT2_FRAC);
			mag = mag + (mag >> 32) * sq + (((mag & 64'hFFFF_FFFF) * sq + 64'h8000_0000) >> 32);
		end
		mag = mag << (p / 2);
		if (neg)
			r.value = (mag > 64'h1_0000_0000_0000) ? -49'sh1_0000_0000_0000
				: hqme_pkg::OUT_W'(-longint'(mag));
		else
			r.value = (mag > 64'hFFFF_FFFF_FFFF) ? 49'shFFFF_FFFF_FFFF
				: hqme_pkg::OUT_W'(mag);
		return r;
	endfunction

	// Driver. A request stays on the ports until the block takes it. Between requests
	// the driver idles about a third of the time, except in a burst in the middle of
	// the run where requests follow back to back.
	always @(posedge clk) begin
		logic taken, hold_off;
		if (arst_n) begin
			taken = start && !busy;
			if (taken) begin
				expected_elements.push_back(matrix_element('{row_level, row_offset,
					col_level, col_offset, 1'b0}));
				issued++;
			end
			if (!(start && busy)) begin
				hold_off = (issued < 300 || issued > 500) && ($urandom_range(0, 99) < 33);
				if (pair_queue.size() > 0 && pair_queue[0].drain_first &&
						expected_elements.size() > 0)
					hold_off = 1'b1;
				if (pair_queue.size() > 0 && !hold_off) begin
					row_level <= pair_queue[0].row_level;
					row_offset <= pair_queue[0].row_offset;
					col_level <= pair_queue[0].col_level;
					col_offset <= pair_queue[0].col_offset;
					void'(pair_queue.pop_front());
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor. A result lives for exactly one cycle, so it is checked at the edge that
	// ends that cycle. The watchdog counts cycles in which neither a request nor a
	// result is taken.
	always @(posedge clk) begin
		element_t want;
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (expected_elements.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					want = expected_elements.pop_front();
					if (element_value !== want.value) begin
						$error("element_value expected %0d actual %0d", want.value,
							element_value);
						mismatches++;
					end
					if (index_error !== want.err) begin
						$error("index_error expected %0b actual %0b", want.err, index_error);
						mismatches++;
					end
					if (want.value != 0) nonzero_seen++;
					if (want.err) error_seen++;
				end
			end
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no traffic for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic wavelet_pair_t random_pair();
		wavelet_pair_t w;
		w.drain_first = 1'b0;
		w.row_level = 4'($urandom_range(0, 15));
		w.col_level = 4'($urandom_range(0, 15));
		// Keep the two levels close most of the time; that is where the supports
		// overlap without nesting and the element is nonzero.
		if ($urandom_range(0, 99) < 50)
			w.col_level = 4'($urandom_range(w.row_level > 2 ? w.row_level - 2 : 0,
				w.row_level < 13 ? w.row_level + 2 : 15));
		if ($urandom_range(0, 99) < 10) begin
			w.row_offset = 16'($urandom);
			w.col_offset = 16'($urandom);
		end else begin
			w.row_offset = 16'($urandom_range(0, (1 << w.row_level) - 1));
			w.col_offset = 16'($urandom_range(0, (1 << w.col_level) - 1));
		end
		return w;
	endfunction

	initial begin
		wavelet_pair_t w;
		// Directed requests: smallest and largest indices, the right endpoint at one,
		// offsets just out of range, and all-ones offsets.
		pair_queue.push_back('{4'd0, 16'd0, 4'd0, 16'd0, 1'b0});
		pair_queue.push_back('{4'd15, 16'h7FFF, 4'd15, 16'h7FFF, 1'b0});
		pair_queue.push_back('{4'd15, 16'd0, 4'd15, 16'd0, 1'b0});
		pair_queue.push_back('{4'd3, 16'd7, 4'd3, 16'd7, 1'b0});
		pair_queue.push_back('{4'd1, 16'd1, 4'd0, 16'd0, 1'b0});
		pair_queue.push_back('{4'd0, 16'd0, 4'd1, 16'd1, 1'b0});
		pair_queue.push_back('{4'd1, 16'd0, 4'd2, 16'd1, 1'b0});
		pair_queue.push_back('{4'd2, 16'd1, 4'd1, 16'd0, 1'b0});
		pair_queue.push_back('{4'd4, 16'd5, 4'd3, 16'd2, 1'b0});
		pair_queue.push_back('{4'd0, 16'd1, 4'd0, 16'd0, 1'b0});
		pair_queue.push_back('{4'd0, 16'd0, 4'd0, 16'd1, 1'b0});
		pair_queue.push_back('{4'd15, 16'h8000, 4'd2, 16'd0, 1'b0});
		pair_queue.push_back('{4'd2, 16'd0, 4'd15, 16'hFFFF, 1'b0});
		pair_queue.push_back('{4'd15, 16'hFFFF, 4'd15, 16'hFFFF, 1'b0});
		pair_queue.push_back('{4'd14, 16'h3FFF, 4'd15, 16'h7FFF, 1'b0});
		pair_queue.push_back('{4'd8, 16'd100, 4'd8, 16'd3, 1'b0});
		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			w = random_pair();
			w.drain_first = (i == 600);
			pair_queue.push_back(w);
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (pair_queue.size() > 0 || start || expected_elements.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Checked %0d matrix elements: %0d nonzero, %0d with bad indices.",
			results_seen, nonzero_seen, error_seen);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

[files.f]
+incdir+src
src/hqme_pkg.sv
src/hqme_ctrl.sv
src/hqme_datapath.sv
src/haar_question_mark_matrix_element.sv
src/hqme_checker.sv
tb/tb_haar_question_mark_matrix_element.sv
